@@ rtl/stbs_pkg.sv @@
// shared types and constants for the sorted table search block
package stbs_pkg;

    // fixed field widths
    localparam int VALUE_WIDTH = 32;
    localparam int INDEX_W     = 10;
    localparam int LEN_W       = 11;
    localparam int POS_W       = 12;
    // internal search index: holds -2 .. 2048
    localparam int SIDX_W      = POS_W + 1;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_EXACT  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_RANGE  = 2'd3;

    // markers for "no position" and "no border"
    localparam logic signed [SIDX_W-1:0] POS_NONE    = -13'sd1;
    localparam logic signed [SIDX_W-1:0] BORDER_NONE = -13'sd2;

    typedef struct packed {
        logic        [1:0]             opcode;
        logic        [INDEX_W-1:0]     entry_index;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic signed [POS_W-1:0] first_position;
        logic signed [POS_W-1:0] last_position;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_query;
        logic write_entry;
        logic issue_read;
        logic compare;
        logic next_pass;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lo_le_hi;
        logic is_range;
        logic pass;
        logic eq;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/sorted_table_binary_search.sv @@
// Sorted table bisection search, top level. A write item (opcode 0) stores a signed
// word at entry_index and gives no result; entries at or above TABLE_DEPTH
// are dropped. A query item searches entries 0 .. min(table_length, TABLE_DEPTH)-1 with
// midpoint (low+high)/2 and gives one result item: exact mode returns the hit index or
// -1, insert mode the hit index or the insertion point, range mode the first and last
// index of the value or -1/-1. Each probe is one memory read followed by one
// compare, and a range query bisects twice, once for each border. Only one query is
// in flight; the next item is taken while the result waits in the output register.
// table_length is written through the configuration channel, which is always ready,
// and should only be changed while no query is in progress.
module sorted_table_binary_search
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // memory and search datapath
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/stbs_ctrl.sv @@
// search sequencer: accepts items and steps the bisection probes
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    output logic       o_in_ready,
    output t_cmd       o_cmd,
    input  t_stat      i_stat
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TEST   = 4'b0010,
        S_CMP    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_WRITE) begin
                        o_cmd.write_entry = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_state          = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (i_stat.lo_le_hi) begin
                    o_cmd.issue_read = 1'b1;
                    n_state          = S_CMP;
                end else if (i_stat.is_range && !i_stat.pass) begin
                    o_cmd.next_pass = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                if (!i_stat.is_range && i_stat.eq) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_TEST;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/stbs_datapath.sv @@
// table memory, search bounds, compare and result register
module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  t_in_item         i_in_item,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [VALUE_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rdata;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic        [LEN_W-1:0]       r_table_length;
    logic        [1:0]             r_mode;
    logic signed [SIDX_W-1:0]      r_lo, r_hi, r_mid, r_border, r_lb;
    logic                          r_pass;
    logic                          r_hit;
    logic                          r_out_valid;
    t_out_item                     r_out_item;

    logic signed [SIDX_W-1:0] active_len;
    logic        [SIDX_W-1:0] mid_sum;
    logic signed [SIDX_W-1:0] mid;
    logic signed [SIDX_W-1:0] border_gap;
    logic                     lt, eq;
    t_out_item                result;

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (i_cfg_valid) begin
            r_table_length <= i_cfg_data;
        end
    end

    // length capped at the table depth
    assign active_len = (32'(r_table_length) > TABLE_DEPTH) ? SIDX_W'(TABLE_DEPTH)
                                                             : SIDX_W'(r_table_length);

    // midpoint of two non-negative bounds
    assign mid_sum = {1'b0, r_lo[POS_W-1:0]} + {1'b0, r_hi[POS_W-1:0]};
    assign mid     = {1'b0, mid_sum[SIDX_W-1:1]};

    // table memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && (32'(i_in_item.entry_index) < TABLE_DEPTH)) begin
            r_mem[ADDR_W'(i_in_item.entry_index)] <= i_in_item.value;
        end
        if (i_cmd.issue_read) begin
            r_rdata <= r_mem[ADDR_W'($unsigned(mid))];
        end
    end

    // probe compare
    assign lt = (r_rdata < r_key);
    assign eq = (r_rdata == r_key);

    // search bounds and borders
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_key    <= i_in_item.value;
            r_mode   <= i_in_item.opcode;
            r_lo     <= '0;
            r_hi     <= active_len - SIDX_W'(1);
            r_border <= BORDER_NONE;
            r_pass   <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.next_pass) begin
            r_lb     <= r_border;
            r_lo     <= '0;
            r_hi     <= active_len - SIDX_W'(1);
            r_border <= BORDER_NONE;
            r_pass   <= 1'b1;
        end else if (i_cmd.issue_read) begin
            r_mid <= mid;
        end else if (i_cmd.compare) begin
            if (r_mode != OP_RANGE) begin
                if (lt) begin
                    r_lo <= r_mid + SIDX_W'(1);
                end else if (!eq) begin
                    r_hi <= r_mid - SIDX_W'(1);
                end else begin
                    r_hit <= 1'b1;
                end
            end else if (!r_pass) begin
                // left border: last index below the target
                if (lt) begin
                    r_lo <= r_mid + SIDX_W'(1);
                end else begin
                    r_hi     <= r_mid - SIDX_W'(1);
                    r_border <= r_mid - SIDX_W'(1);
                end
            end else begin
                // right border: first index above the target
                if (lt || eq) begin
                    r_lo     <= r_mid + SIDX_W'(1);
                    r_border <= r_mid + SIDX_W'(1);
                end else begin
                    r_hi <= r_mid - SIDX_W'(1);
                end
            end
        end
    end

    // result from the final search state
    assign border_gap = r_border - r_lb;

    always_comb begin
        result = '0;
        case (r_mode)
            OP_EXACT: begin
                result.found          = r_hit;
                result.first_position = r_hit ? r_mid[POS_W-1:0] : POS_NONE[POS_W-1:0];
                result.last_position  = result.first_position;
            end
            OP_INSERT: begin
                result.found          = r_hit;
                result.first_position = r_hit ? r_mid[POS_W-1:0]
                                              : POS_W'(r_hi + SIDX_W'(1));
                result.last_position  = result.first_position;
            end
            OP_RANGE: begin
                if ((r_lb != BORDER_NONE) && (r_border != BORDER_NONE)
                        && (border_gap > SIDX_W'(1))) begin
                    result.found          = 1'b1;
                    result.first_position = POS_W'(r_lb + SIDX_W'(1));
                    result.last_position  = POS_W'(r_border - SIDX_W'(1));
                end else begin
                    result.first_position = POS_NONE[POS_W-1:0];
                    result.last_position  = POS_NONE[POS_W-1:0];
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // status to the sequencer
    assign o_stat.lo_le_hi = (r_lo <= r_hi);
    assign o_stat.is_range = (r_mode == OP_RANGE);
    assign o_stat.pass     = r_pass;
    assign o_stat.eq       = eq;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the sorted table bisection search block
`timescale 1ns / 1ps

module tb;
    import stbs_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int ITEM_TARGET    = 1600;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // predicted search results, kept in order of the queries
    class search_scoreboard;
        logic signed [VALUE_WIDTH-1:0] entries [DEPTH];
        logic [LEN_W-1:0] length_reg;
        t_out_item expected_q [$];
        int mismatches;

        function new();
            length_reg = '0;
            mismatches = 0;
        endfunction

        function void set_length(input logic [LEN_W-1:0] len);
            length_reg = len;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // a write updates the table copy, a query predicts one result item
        function void note_item(input t_in_item it);
            int n, lo, hi, mid, pos, lb, rb, first_pos, last_pos;
            bit hit;
            logic signed [VALUE_WIDTH-1:0] target;
            t_out_item res;
            if (it.opcode == OP_WRITE) begin
                entries[it.entry_index] = it.value;
                return;
            end
            target = it.value;
            n = (length_reg > DEPTH) ? DEPTH : int'(length_reg);
            hit = 1'b0;
            if (it.opcode == OP_RANGE) begin
                // left border: last index below the target
                lo = 0;
                hi = n - 1;
                lb = -2;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (entries[mid] < target) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                        lb = hi;
                    end
                end
                // right border: first index above the target
                lo = 0;
                hi = n - 1;
                rb = -2;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (entries[mid] <= target) begin
                        lo = mid + 1;
                        rb = lo;
                    end else begin
                        hi = mid - 1;
                    end
                end
                first_pos = -1;
                last_pos = -1;
                if (lb != -2 && rb != -2 && rb - lb > 1) begin
                    hit = 1'b1;
                    first_pos = lb + 1;
                    last_pos = rb - 1;
                end
            end else begin
                // plain bisection, stops at the first probe that hits
                lo = 0;
                hi = n - 1;
                pos = -1;
                while (lo <= hi && !hit) begin
                    mid = (lo + hi) / 2;
                    if (entries[mid] < target) begin
                        lo = mid + 1;
                    end else if (entries[mid] > target) begin
                        hi = mid - 1;
                    end else begin
                        hit = 1'b1;
                        pos = mid;
                    end
                end
                if (!hit) begin
                    pos = (it.opcode == OP_EXACT) ? -1 : hi + 1;
                end
                first_pos = pos;
                last_pos = pos;
            end
            res.found = hit;
            res.first_position = first_pos[POS_W-1:0];
            res.last_position = last_pos[POS_W-1:0];
            expected_q.push_back(res);
        endfunction

        // compare a result item with the oldest prediction
        function void check_result(input t_out_item got);
            t_out_item exp_item;
            if (expected_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result item: found=%0b first=%0d last=%0d",
                             got.found, got.first_position, got.last_position);
                end
                mismatches++;
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.found !== exp_item.found ||
                got.first_position !== exp_item.first_position ||
                got.last_position !== exp_item.last_position) begin
                if (mismatches < 10) begin
                    $write("mismatch: expected found=%0b first=%0d last=%0d,",
                           exp_item.found, exp_item.first_position, exp_item.last_position);
                    $display(" got found=%0b first=%0d last=%0d",
                             got.found, got.first_position, got.last_position);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_ready;
    t_out_item        out_item;

    search_scoreboard sb = new();

    int send_idle_pct;
    int stall_pct;
    int item_count;
    int quiet_cycles;
    bit hold_request;

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, and one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result checking
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_result(out_item);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_item(it);
        item_count++;
    endtask

    task automatic write_entry(input int idx, input logic signed [VALUE_WIDTH-1:0] val);
        t_in_item it;
        it.opcode = OP_WRITE;
        it.entry_index = idx[INDEX_W-1:0];
        it.value = val;
        send_item(it);
    endtask

    // queries carry a random don't-care address
    task automatic query(input logic [1:0] op, input logic signed [VALUE_WIDTH-1:0] target);
        t_in_item it;
        it.opcode = op;
        it.entry_index = INDEX_W'($urandom);
        it.value = target;
        send_item(it);
    endtask

    // drain every result, then allow for a write still in flight
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do @(posedge clk); while (!cfg_ready);
        sb.set_length(len);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] random_query_op();
        case ($urandom_range(2))
            0: begin
                return OP_EXACT;
            end
            1: begin
                return OP_INSERT;
            end
            default: begin
                return OP_RANGE;
            end
        endcase
    endfunction

    // mostly values held in the table or next to them, some extremes and noise
    function automatic logic signed [VALUE_WIDTH-1:0] pick_target(input int n);
        int r;
        logic signed [VALUE_WIDTH-1:0] v;
        r = $urandom_range(99);
        if (n > 0 && r < 45) begin
            v = sb.entries[$urandom_range(n - 1)];
        end else if (n > 0 && r < 65) begin
            v = sb.entries[$urandom_range(n - 1)] + (r[0] ? 1 : -1);
        end else if (r < 75) begin
            v = r[0] ? VAL_MAX : VAL_MIN;
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    // idling pattern per phase
    task automatic set_traffic(input int phase);
        case (phase % 4)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 47;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 47;
            end
            default: begin
                send_idle_pct = 18;
                stall_pct = 18;
            end
        endcase
    endtask

    // stimulus
    initial begin
        int vals [$];
        int big_lengths [4];
        int phase, n, nq, r, base;
        bit unsorted, narrow;
        logic signed [VALUE_WIDTH-1:0] v;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        item_count = 0;
        set_traffic(0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        write_length(LEN_W'(0));
        query(OP_EXACT, 5);
        query(OP_INSERT, 5);
        query(OP_RANGE, 5);
        query(OP_RANGE, VAL_MIN);

        // small table with both extremes and a run of duplicates
        write_entry(0, VAL_MIN);
        write_entry(1, -3);
        write_entry(2, 7);
        write_entry(3, 7);
        write_entry(4, 7);
        write_entry(5, VAL_MAX);
        write_length(LEN_W'(6));
        query(OP_EXACT, VAL_MIN);
        query(OP_EXACT, VAL_MAX);
        query(OP_EXACT, 7);
        query(OP_EXACT, 8);
        query(OP_INSERT, 8);
        query(OP_INSERT, -4);
        query(OP_INSERT, VAL_MAX);
        query(OP_RANGE, 7);
        query(OP_RANGE, 8);
        query(OP_RANGE, VAL_MIN);
        query(OP_RANGE, VAL_MAX);

        // target above every entry gives the end as insertion point
        write_length(LEN_W'(3));
        query(OP_INSERT, 100);
        query(OP_RANGE, -3);

        // random phases
        item_count = 0;
        for (phase = 0; item_count < ITEM_TARGET; phase++) begin
            set_traffic(phase);
            if (phase == 5) begin
                // full table, then lengths at, above and below the depth
                v = VAL_MIN;
                for (int i = 0; i < DEPTH; i++) begin
                    if (i == DEPTH - 1) begin
                        v = VAL_MAX;
                    end
                    write_entry(i, v);
                    if ($urandom_range(4) != 0) begin
                        v = v + int'($urandom_range(1, 3000000));
                    end
                end
                big_lengths[0] = DEPTH;
                big_lengths[1] = 2047;
                big_lengths[2] = $urandom_range(DEPTH + 1, 2046);
                big_lengths[3] = $urandom_range(1, DEPTH - 1);
                foreach (big_lengths[k]) begin
                    write_length(LEN_W'(big_lengths[k]));
                    n = (big_lengths[k] > DEPTH) ? DEPTH : big_lengths[k];
                    repeat (30) query(random_query_op(), pick_target(n));
                end
            end else begin
                // small table: length first, then fill every live entry
                r = $urandom_range(99);
                if (r < 8) begin
                    n = 0;
                end else if (r < 16) begin
                    n = 1;
                end else if (r < 22) begin
                    n = 2;
                end else begin
                    n = $urandom_range(3, 48);
                end
                write_length(LEN_W'(n));
                narrow = ($urandom_range(1) == 0);
                unsorted = ($urandom_range(99) < 12);
                base = $urandom;
                vals.delete();
                for (int i = 0; i < n; i++) begin
                    if (narrow) begin
                        vals.push_back(base + int'($urandom_range(n / 2 + 1)));
                    end else begin
                        vals.push_back(int'($urandom));
                    end
                end
                if (!unsorted) begin
                    vals.sort();
                end
                foreach (vals[i]) begin
                    write_entry(i, vals[i]);
                end

                // long receiver hold-off so the block backs up
                if (phase == 2 || phase == 9) begin
                    hold_request = 1'b1;
                end

                // queries, with the odd stray write mixed in
                nq = $urandom_range(n + 8, 3 * n + 16);
                repeat (nq) begin
                    if ($urandom_range(99) < 5) begin
                        write_entry($urandom_range(DEPTH - 1), $urandom);
                    end else begin
                        query(random_query_op(), pick_target(n));
                    end
                end
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/stbs_pkg.sv
rtl/stbs_ctrl.sv
rtl/stbs_datapath.sv
rtl/sorted_table_binary_search.sv
bench/tb.sv
